// File: rtl/lsp_pkg.sv
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared types and constants of the LED strip pattern generator.
// ----------------------------------------------------------------------------
package lsp_pkg;

  localparam logic [2:0] MODE_OFF      = 3'd0;
  localparam logic [2:0] MODE_STATIC   = 3'd1;
  localparam logic [2:0] MODE_SOLID    = 3'd2;
  localparam logic [2:0] MODE_MOTION   = 3'd3;
  localparam logic [2:0] MODE_BLINK    = 3'd4;
  localparam logic [2:0] MODE_ROTATION = 3'd5;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_LIST  = 2'd1;
  localparam logic [1:0] OP_TGT   = 2'd2;

  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_BASE     = 3'd1;
  localparam logic [2:0] REG_SECOND   = 3'd2;
  localparam logic [2:0] REG_INTERVAL = 3'd3;
  localparam logic [2:0] REG_SEGMENT  = 3'd4;
  localparam logic [2:0] REG_FSTEPS   = 3'd5;
  localparam logic [2:0] REG_LISTCNT  = 3'd6;
  localparam logic [2:0] REG_TGTCNT   = 3'd7;

  localparam logic [2:0]  MOTION_SLOTS = 3'd6;
  localparam logic [23:0] COLOR_BLACK  = 24'h000000;
  localparam logic [23:0] COLOR_WHITE  = 24'hFFFFFF;
  localparam logic [7:0]  FADE_CNT_MAX = 8'hFF;
  localparam logic [15:0] INTERVAL_RST = 16'd100;
  localparam logic [3:0]  DIV_LAST     = 4'd15;

  typedef struct packed {
    logic       take_item;
    logic       walk_clear;
    logic       walk_step;
    logic       list_rd;
    logic       pix_emit;
    logic       tgt_rd_cur;
    logic       tgt_rd_next;
    logic       fade_begin;
    logic       fade_load;
    logic       mul_ch;
    logic       div_step;
    logic       ch_store;
    logic       fade_finish;
    logic       frame_book;
  } lsp_cmd_t;

  typedef struct packed {
    logic frame_tick;
    logic frame_emits;
    logic fade_on;
    logic walk_at_off;
    logic pix_last;
    logic out_free;
    logic restart_need;
    logic div_last;
    logic ch_last;
  } lsp_status_t;

endpackage

// File: rtl/led_strip_pattern_generator.sv
// ----------------------------------------------------------------------------
// led_strip_pattern_generator
// Frame generator for an addressable LED strip with color fading.
// ----------------------------------------------------------------------------
// Each input request is a millisecond tick or a write into the color list or
// the fade target table. Table writes and ticks that do not complete an
// interval are taken in the idle state. A tick that completes an interval
// starts a frame: the pixel walk first steps from pixel zero to the rotation
// offset, then emits LED_COUNT pixel requests, each with one table read and
// one output load; a full output register stalls the walk. With fading
// enabled, target lookups follow (and, when a new fade begins, a read and load
// of the next target), then for each of the three color channels a multiply
// step, a restoring divide and a store step. A bookkeeping step ends every
// frame. The input is not ready again until the frame and fade are complete.
// Static mode emits no pixels but still advances the fade.
module led_strip_pattern_generator #(
  parameter int LED_COUNT   = 32,
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [3:0]  in_entry_index,
  input  logic [23:0] in_entry_color,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_pixel_index,
  output logic [23:0] out_pixel_color,
  output logic        out_last
);
  import lsp_pkg::*;

  // Command and status groups between the sequencer and the datapath.
  lsp_cmd_t    cmd;
  lsp_status_t st;

  lsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  lsp_datapath #(
    .LED_COUNT   (LED_COUNT),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_op           (in_op),
    .in_entry_index  (in_entry_index),
    .in_entry_color  (in_entry_color),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_index (out_pixel_index),
    .out_pixel_color (out_pixel_color),
    .out_last        (out_last),
    .cmd             (cmd),
    .st              (st)
  );

endmodule

// File: rtl/lsp_ctrl.sv
// ----------------------------------------------------------------------------
// lsp_ctrl
// Sequencer: request intake, pixel walk, fade channel loop, bookkeeping.
// ----------------------------------------------------------------------------
module lsp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lsp_pkg::lsp_status_t st,
  output lsp_pkg::lsp_cmd_t    cmd
);
  import lsp_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_SEEK     = 13'b0000000000010,
    S_PIX_RD   = 13'b0000000000100,
    S_PIX_OUT  = 13'b0000000001000,
    S_FADE_RD  = 13'b0000000010000,
    S_FADE_CHK = 13'b0000000100000,
    S_FADE_RD2 = 13'b0000001000000,
    S_FADE_LD  = 13'b0000010000000,
    S_MUL      = 13'b0000100000000,
    S_DIV      = 13'b0001000000000,
    S_STORE    = 13'b0010000000000,
    S_FIN      = 13'b0100000000000,
    S_BOOK     = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  state_t fade_entry;

  assign in_ready   = (state_r == S_IDLE);
  assign fade_entry = st.fade_on ? S_FADE_RD : S_BOOK;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_item = 1'b1;
          if (st.frame_tick) begin
            cmd.walk_clear = 1'b1;
            state_nxt = st.frame_emits ? S_SEEK : fade_entry;
          end
        end
      end
      S_SEEK: begin
        if (st.walk_at_off) begin
          state_nxt = S_PIX_RD;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_PIX_RD: begin
        cmd.list_rd = 1'b1;
        state_nxt   = S_PIX_OUT;
      end
      S_PIX_OUT: begin
        if (st.out_free) begin
          cmd.pix_emit  = 1'b1;
          cmd.walk_step = 1'b1;
          state_nxt = st.pix_last ? fade_entry : S_PIX_RD;
        end
      end
      S_FADE_RD: begin
        cmd.tgt_rd_cur = 1'b1;
        state_nxt      = S_FADE_CHK;
      end
      S_FADE_CHK: begin
        cmd.fade_begin = 1'b1;
        state_nxt = st.restart_need ? S_FADE_RD2 : S_MUL;
      end
      S_FADE_RD2: begin
        cmd.tgt_rd_next = 1'b1;
        state_nxt       = S_FADE_LD;
      end
      S_FADE_LD: begin
        cmd.fade_load = 1'b1;
        state_nxt     = S_MUL;
      end
      S_MUL: begin
        cmd.mul_ch = 1'b1;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        cmd.ch_store = 1'b1;
        state_nxt = st.ch_last ? S_FIN : S_MUL;
      end
      S_FIN: begin
        cmd.fade_finish = 1'b1;
        state_nxt       = S_BOOK;
      end
      S_BOOK: begin
        cmd.frame_book = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state register lost its one-hot code");
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && st.div_last) |=> (state_r == S_STORE))
    else $error("divider did not hand over to store");
  a_no_emit_late: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pix_emit |-> st.out_free)
    else $error("pixel emitted into a full output register");

endmodule

// File: rtl/lsp_datapath.sv
// ----------------------------------------------------------------------------
// lsp_datapath
// Configuration, pattern state, color tables, pixel walk and fade divider.
// ----------------------------------------------------------------------------
module lsp_datapath #(
  parameter int LED_COUNT   = 32,
  parameter int TABLE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [23:0]          cfg_wdata,
  input  logic [1:0]           in_op,
  input  logic [3:0]           in_entry_index,
  input  logic [23:0]          in_entry_color,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [5:0]           out_pixel_index,
  output logic [23:0]          out_pixel_color,
  output logic                 out_last,
  input  lsp_pkg::lsp_cmd_t    cmd,
  output lsp_pkg::lsp_status_t st
);
  import lsp_pkg::*;

  localparam int         AW       = $clog2(TABLE_DEPTH);
  localparam logic [5:0] LAST_IDX = 6'(LED_COUNT - 1);
  localparam logic [4:0] DEPTH5   = 5'(TABLE_DEPTH);

  // Configuration registers.
  logic [2:0]  mode_r;
  logic [23:0] second_r;
  logic [15:0] interval_r;
  logic [7:0]  seg_r, fsteps_r;
  logic [4:0]  lcnt_r, tcnt_r;

  // Pattern and fade state.
  logic [15:0] ticks_r;
  logic [5:0]  offset_r;
  logic        blink_r, first_r;
  logic [23:0] cur_r, fstart_r, fgoal_r, newcol_r;
  logic [7:0]  fcnt_r;
  logic [3:0]  tp_r;

  // Pixel walk.
  logic [5:0] pix_r, e_r;
  logic [7:0] pos_r;
  logic [2:0] s6_r;
  logic [3:0] sn_r;

  // Tables.
  logic [23:0] list_mem [TABLE_DEPTH];
  logic [23:0] tgt_mem  [TABLE_DEPTH];
  logic [23:0] list_q_r, tgt_q_r;

  // Fade channel unit.
  logic [1:0]  ch_r;
  logic [7:0]  s_r, rem_r;
  logic        dir_r;
  logic [15:0] dvd_r;
  logic [3:0]  dcnt_r;

  logic        out_valid_r, out_last_r;
  logic [5:0]  out_idx_r;
  logic [23:0] out_col_r;

  logic [15:0] ticks_inc;
  logic [7:0]  seg_eff, steps_eff;
  logic [4:0]  ln, tn;
  logic [3:0]  tp_step, tp_new;
  logic [7:0]  sb, gb, diff;
  logic [8:0]  trial;
  logic [23:0] pix_col;
  logic [7:0]  chan_res;

  assign ticks_inc = (ticks_r == 16'hFFFF) ? ticks_r : ticks_r + 16'd1;
  assign seg_eff   = (seg_r == 8'd0) ? 8'd1 : seg_r;
  assign steps_eff = (fsteps_r == 8'd0) ? 8'd1 : fsteps_r;
  assign ln        = (lcnt_r > DEPTH5) ? DEPTH5 : lcnt_r;
  assign tn        = (tcnt_r > DEPTH5) ? DEPTH5 : tcnt_r;
  assign tp_step   = first_r ? 4'd0 : tp_r + 4'd1;
  assign tp_new    = ({1'b0, tp_step} >= tn) ? 4'd0 : tp_step;

  assign st.frame_tick   = (in_op == OP_TICK) && (ticks_inc >= interval_r);
  assign st.frame_emits  = (mode_r == MODE_OFF) || (mode_r == MODE_SOLID) ||
                           (mode_r == MODE_MOTION) || (mode_r == MODE_BLINK) ||
                           (mode_r == MODE_ROTATION);
  assign st.fade_on      = (tn != 5'd0);
  assign st.walk_at_off  = (e_r == offset_r);
  assign st.pix_last     = (pix_r == LAST_IDX);
  assign st.out_free     = !out_valid_r || out_ready;
  assign st.restart_need = first_r || (cur_r == tgt_q_r) || (fcnt_r >= steps_eff);
  assign st.div_last     = (dcnt_r == DIV_LAST);
  assign st.ch_last      = (ch_r == 2'd2);

  // Channel operands: channel 0 is red, 1 green, 2 blue.
  always_comb begin
    case (ch_r)
      2'd0:    begin sb = fstart_r[23:16]; gb = fgoal_r[23:16]; end
      2'd1:    begin sb = fstart_r[15:8];  gb = fgoal_r[15:8];  end
      default: begin sb = fstart_r[7:0];   gb = fgoal_r[7:0];   end
    endcase
  end
  assign diff     = (sb > gb) ? sb - gb : gb - sb;
  assign trial    = {rem_r, dvd_r[15]};
  assign chan_res = dir_r ? s_r - dvd_r[7:0] : s_r + dvd_r[7:0];

  always_comb begin
    case (mode_r)
      MODE_SOLID:    pix_col = cur_r;
      MODE_MOTION:   pix_col = (s6_r == 3'd0) ? cur_r :
                               ((s6_r == 3'd1) ? second_r : COLOR_BLACK);
      MODE_BLINK:    pix_col = blink_r ? COLOR_BLACK : cur_r;
      MODE_ROTATION: pix_col = (ln != 5'd0) ? list_q_r : COLOR_BLACK;
      default:       pix_col = COLOR_BLACK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item && in_op == OP_LIST && {1'b0, in_entry_index} < DEPTH5) begin
      list_mem[in_entry_index[AW-1:0]] <= in_entry_color;
    end
    if (cmd.take_item && in_op == OP_TGT && {1'b0, in_entry_index} < DEPTH5) begin
      tgt_mem[in_entry_index[AW-1:0]] <= in_entry_color;
    end
    if (cmd.list_rd) begin
      list_q_r <= list_mem[sn_r[AW-1:0]];
    end
    if (cmd.tgt_rd_cur) begin
      tgt_q_r <= tgt_mem[tp_r[AW-1:0]];
    end else if (cmd.tgt_rd_next) begin
      tgt_q_r <= tgt_mem[tp_new[AW-1:0]];
    end
  end

  // Walk and fade datapath registers (payload, no reset).
  always_ff @(posedge clk) begin
    if (cmd.walk_clear) begin
      pix_r <= '0; e_r <= '0; pos_r <= '0; s6_r <= '0; sn_r <= '0;
    end else if (cmd.walk_step) begin
      if (cmd.pix_emit) begin
        pix_r <= pix_r + 6'd1;
      end
      if (e_r == LAST_IDX) begin
        e_r <= '0; pos_r <= '0; s6_r <= '0; sn_r <= '0;
      end else begin
        e_r <= e_r + 6'd1;
        if (pos_r + 8'd1 == seg_eff) begin
          pos_r <= '0;
          s6_r  <= (s6_r == MOTION_SLOTS - 3'd1) ? 3'd0 : s6_r + 3'd1;
          sn_r  <= ({1'b0, sn_r} + 5'd1 >= ln) ? 4'd0 : sn_r + 4'd1;
        end else begin
          pos_r <= pos_r + 8'd1;
        end
      end
    end
    if (cmd.pix_emit) begin
      out_idx_r  <= pix_r;
      out_col_r  <= pix_col;
      out_last_r <= (pix_r == LAST_IDX);
    end
    if (cmd.fade_begin) begin
      ch_r <= 2'd0;
    end else if (cmd.ch_store) begin
      ch_r <= ch_r + 2'd1;
    end
    if (cmd.mul_ch) begin
      s_r    <= sb;
      dir_r  <= (sb > gb);
      dvd_r  <= diff * fcnt_r;
      rem_r  <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r + 4'd1;
      if (trial >= {1'b0, steps_eff}) begin
        rem_r <= 8'(trial - {1'b0, steps_eff});
        dvd_r <= {dvd_r[14:0], 1'b1};
      end else begin
        rem_r <= trial[7:0];
        dvd_r <= {dvd_r[14:0], 1'b0};
      end
    end
    if (cmd.ch_store) begin
      case (ch_r)
        2'd0:    newcol_r[23:16] <= chan_res;
        2'd1:    newcol_r[15:8]  <= chan_res;
        default: newcol_r[7:0]   <= chan_res;
      endcase
    end
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_OFF; second_r <= COLOR_WHITE; interval_r <= INTERVAL_RST;
      seg_r <= 8'd1; fsteps_r <= FADE_CNT_MAX; lcnt_r <= '0; tcnt_r <= '0;
      ticks_r <= '0; offset_r <= '0; blink_r <= 1'b0; first_r <= 1'b1;
      cur_r <= COLOR_WHITE; fstart_r <= '0; fgoal_r <= '0; fcnt_r <= '0;
      tp_r <= '0; out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:     begin mode_r <= cfg_wdata[2:0]; tp_r <= '0; first_r <= 1'b1; end
          REG_BASE:     cur_r      <= cfg_wdata;
          REG_SECOND:   second_r   <= cfg_wdata;
          REG_INTERVAL: interval_r <= cfg_wdata[15:0];
          REG_SEGMENT:  seg_r      <= cfg_wdata[7:0];
          REG_FSTEPS:   fsteps_r   <= cfg_wdata[7:0];
          REG_LISTCNT:  lcnt_r     <= cfg_wdata[4:0];
          REG_TGTCNT:   tcnt_r     <= cfg_wdata[4:0];
          default:      ;
        endcase
      end
      if (cmd.take_item && in_op == OP_TICK) begin
        ticks_r <= st.frame_tick ? 16'd0 : ticks_inc;
      end
      if (cmd.pix_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.fade_load) begin
        tp_r     <= tp_new;
        fstart_r <= cur_r;
        fgoal_r  <= tgt_q_r;
        fcnt_r   <= '0;
      end
      if (cmd.fade_finish) begin
        cur_r <= newcol_r;
        if (fcnt_r != FADE_CNT_MAX) begin
          fcnt_r <= fcnt_r + 8'd1;
        end
      end
      if (cmd.frame_book) begin
        offset_r <= (offset_r == LAST_IDX) ? 6'd0 : offset_r + 6'd1;
        blink_r  <= ~blink_r;
        first_r  <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_index = out_idx_r;
  assign out_pixel_color = out_col_r;
  assign out_last        = out_last_r;

  a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
    offset_r <= LAST_IDX)
    else $error("rotation offset beyond the strip");
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pix_emit |-> (s6_r < MOTION_SLOTS))
    else $error("motion slot out of range");
  a_tp_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, tp_r} < DEPTH5)
    else $error("target pointer beyond table");

endmodule
